FILE: src/mfcd_pkg.sv
//------------------------------------------------------------------------------
// mfcd_pkg: shared definitions for the marker framed command decoder
// Frame geometry, command codes, field offsets and the structs that pass
// between the front end, the job queue and the decode sequencer.
//------------------------------------------------------------------------------
package mfcd_pkg;

	// Frame geometry.
	localparam int FRAME_BYTES = 64;
	localparam int NAME_BYTES  = 32;
	localparam int FILL_W      = $clog2(FRAME_BYTES + 1);
	localparam int IDX_W       = $clog2(FRAME_BYTES);
	localparam int MEM_DEPTH   = 2 * FRAME_BYTES;
	localparam int ADDR_W      = $clog2(MEM_DEPTH);
	localparam int NIDX_W      = $clog2(NAME_BYTES);
	localparam int OFF_W       = 6;
	localparam int FCNT_W      = 4;

	// Marker bytes.
	localparam logic [7:0] MARK_FF = 8'hFF;
	localparam logic [7:0] MARK_AA = 8'hAA;

	// Command characters found at the command offset.
	localparam logic [7:0] CODE_ADD      = 8'h41;
	localparam logic [7:0] CODE_REMOVE   = 8'h44;
	localparam logic [7:0] CODE_SYNC     = 8'h53;
	localparam logic [7:0] CODE_FINISHED = 8'h46;
	localparam logic [7:0] CODE_REQUEST  = 8'h52;
	localparam logic [7:0] CODE_UPDATE   = 8'h55;

	// Field offsets, counted from the first byte of the start marker.
	localparam int CMD_OFFSET        = 2;
	localparam int ADD_ID_TOP        = 38;
	localparam int REMOVE_ID_FIRST   = 3;
	localparam int UPDATE_UID_FIRST  = 3;
	localparam int UPDATE_ID_TOP     = 43;
	localparam int ADD_NAME_FIRST    = 3;
	localparam int UPDATE_NAME_FIRST = 8;
	localparam int ID_BYTES          = 4;
	localparam int UID_BYTES         = 5;

	// Decoded command.
	typedef enum logic [2:0] {
		CMD_ADD      = 3'd0,
		CMD_REMOVE   = 3'd1,
		CMD_SYNC     = 3'd2,
		CMD_FINISHED = 3'd3,
		CMD_REQUEST  = 3'd4,
		CMD_UPDATE   = 3'd5,
		CMD_INVALID  = 3'd6
	} cmd_t;

	// Decode sequencer states.
	typedef enum logic [2:0] {
		B_IDLE,
		B_CMD_RD,
		B_CMD_USE,
		B_FLD_RD,
		B_FLD_USE,
		B_NAME_RD,
		B_NAME_USE,
		B_EMIT
	} back_state_t;

	// One closed frame waiting for decode: its buffer bank and length.
	typedef struct packed {
		logic              bank;
		logic [FILL_W-1:0] len;
	} job_t;

	// Queue write side.
	typedef struct packed {
		logic push;
		job_t job;
	} q_wr_t;

	// Queue read side.
	typedef struct packed {
		logic avail;
		job_t job;
	} q_rd_t;

	// Frame buffer write port.
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
	} mem_wr_t;

	// Maps the command character to a command.
	function automatic cmd_t decode_code(input logic [7:0] code);
		cmd_t c;
		unique case (code)
			CODE_ADD:      c = CMD_ADD;
			CODE_REMOVE:   c = CMD_REMOVE;
			CODE_SYNC:     c = CMD_SYNC;
			CODE_FINISHED: c = CMD_FINISHED;
			CODE_REQUEST:  c = CMD_REQUEST;
			CODE_UPDATE:   c = CMD_UPDATE;
			default:       c = CMD_INVALID;
		endcase
		return c;
	endfunction

	// Number of id and uid bytes fetched for a command.
	function automatic logic [FCNT_W-1:0] field_count(input cmd_t c);
		logic [FCNT_W-1:0] n;
		unique case (c)
			CMD_ADD:    n = FCNT_W'(ID_BYTES);
			CMD_REMOVE: n = FCNT_W'(ID_BYTES);
			CMD_UPDATE: n = FCNT_W'(ID_BYTES + UID_BYTES);
			default:    n = '0;
		endcase
		return n;
	endfunction

	// Frame offset of the n-th fetched field byte, in shift-in order.
	function automatic logic [OFF_W-1:0] field_offset(input cmd_t c,
		input logic [FCNT_W-1:0] n);
		logic [OFF_W-1:0] off;
		unique case (c)
			CMD_ADD:    off = OFF_W'(ADD_ID_TOP) - OFF_W'(n);
			CMD_REMOVE: off = OFF_W'(REMOVE_ID_FIRST) + OFF_W'(n);
			CMD_UPDATE: begin
				if (n < FCNT_W'(UID_BYTES))
					off = OFF_W'(UPDATE_UID_FIRST) + OFF_W'(n);
				else
					off = OFF_W'(UPDATE_ID_TOP + UID_BYTES) - OFF_W'(n);
			end
			default:    off = OFF_W'(CMD_OFFSET);
		endcase
		return off;
	endfunction

	// True for commands that produce a run of name bytes.
	function automatic logic has_name(input cmd_t c);
		return (c == CMD_ADD) || (c == CMD_UPDATE);
	endfunction

	// Frame offset of the first name byte.
	function automatic logic [OFF_W-1:0] name_base(input cmd_t c);
		return (c == CMD_UPDATE) ? OFF_W'(UPDATE_NAME_FIRST) : OFF_W'(ADD_NAME_FIRST);
	endfunction

endpackage

FILE: src/mfcd_ram.sv
//------------------------------------------------------------------------------
// mfcd_ram: generic single write, single read RAM
// One write port and one read port with registered read data.
//------------------------------------------------------------------------------
module mfcd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Storage write and registered read.
	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule

FILE: src/mfcd_front.sv
//------------------------------------------------------------------------------
// mfcd_front: marker hunt and frame capture
// Hunts for the start marker, writes frame bytes into the current buffer bank
// and posts a decode job when the end marker closes the frame.
//------------------------------------------------------------------------------
module mfcd_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   rx_valid,
	output logic                   rx_stall,
	input  logic [7:0]             rx_byte,
	input  logic                   q_full,
	output mfcd_pkg::q_wr_t        q_wr,
	output mfcd_pkg::mem_wr_t      mem_wr
);

	logic                          hunt_q;
	logic [7:0]                    prev_q;
	logic [mfcd_pkg::FILL_W-1:0]   fill_q;
	logic                          bank_q;
	logic                          accept;
	logic                          start_seen;
	logic                          end_seen;
	logic                          overflow;
	logic [mfcd_pkg::FILL_W-1:0]   fill_inc;
	logic [mfcd_pkg::ADDR_W-1:0]   bank_base;

	// Both banks hold frames awaiting decode: hold the stream.
	assign rx_stall = q_full;
	assign accept   = rx_valid && !rx_stall;

	assign start_seen = (prev_q == mfcd_pkg::MARK_FF) && (rx_byte == mfcd_pkg::MARK_AA);
	assign end_seen   = (prev_q == mfcd_pkg::MARK_AA) && (rx_byte == mfcd_pkg::MARK_FF);
	assign overflow   = fill_q >= mfcd_pkg::FILL_W'(mfcd_pkg::FRAME_BYTES);
	assign fill_inc   = fill_q + mfcd_pkg::FILL_W'(1);
	assign bank_base  = bank_q ? mfcd_pkg::ADDR_W'(mfcd_pkg::FRAME_BYTES) : '0;

	// Frame byte write into the current bank.
	always_comb begin
		mem_wr.we   = accept && !hunt_q && !overflow;
		mem_wr.addr = bank_base + mfcd_pkg::ADDR_W'(fill_q[mfcd_pkg::IDX_W-1:0]);
		mem_wr.data = rx_byte;
	end

	// Job posted when the end marker closes the frame.
	always_comb begin
		q_wr.push     = mem_wr.we && end_seen;
		q_wr.job.bank = bank_q;
		q_wr.job.len  = fill_inc;
	end

	// Hunt, fill and bank control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hunt_q <= 1'b1;
			prev_q <= '0;
			fill_q <= '0;
			bank_q <= 1'b0;
		end else if (accept) begin
			prev_q <= rx_byte;
			if (hunt_q) begin
				if (start_seen) begin
					hunt_q <= 1'b0;
					fill_q <= mfcd_pkg::FILL_W'(2);
				end
			end else if (overflow) begin
				hunt_q <= 1'b1;
				fill_q <= '0;
			end else if (end_seen) begin
				hunt_q <= 1'b1;
				fill_q <= '0;
				bank_q <= !bank_q;
			end else begin
				fill_q <= fill_inc;
			end
		end
	end

endmodule

FILE: src/mfcd_queue.sv
//------------------------------------------------------------------------------
// mfcd_queue: two-entry decode job queue
// Holds closed frames between capture and decode; the head stays until the
// sequencer has delivered the frame's last result.
//------------------------------------------------------------------------------
module mfcd_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  mfcd_pkg::q_wr_t     q_wr,
	input  logic                pop,
	output mfcd_pkg::q_rd_t     q_rd,
	output logic                full
);

	mfcd_pkg::job_t entry_q [2];
	logic           wptr_q;
	logic           rptr_q;
	logic [1:0]     count_q;

	assign full       = count_q == 2'd2;
	assign q_rd.avail = count_q != 2'd0;
	assign q_rd.job   = entry_q[rptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (q_wr.push)
			entry_q[wptr_q] <= q_wr.job;
	end

	// Pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= '0;
		end else begin
			if (q_wr.push)
				wptr_q <= !wptr_q;
			if (pop)
				rptr_q <= !rptr_q;
			if (q_wr.push && !pop)
				count_q <= count_q + 2'd1;
			else if (pop && !q_wr.push)
				count_q <= count_q - 2'd1;
		end
	end

endmodule

FILE: src/mfcd_back.sv
//------------------------------------------------------------------------------
// mfcd_back: frame decode sequencer
// Reads the queued frame from its buffer bank one byte at a time, gathers the
// command, id and uid, then streams the result transactions.
//------------------------------------------------------------------------------
module mfcd_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mfcd_pkg::q_rd_t               q_rd,
	output logic                          pop,
	output logic [mfcd_pkg::ADDR_W-1:0]   raddr,
	input  logic [7:0]                    rdata,
	output logic                          res_valid,
	input  logic                          res_stall,
	output logic [2:0]                    command,
	output logic [31:0]                   card_id,
	output logic [39:0]                   card_uid,
	output logic [7:0]                    name_byte,
	output logic [4:0]                    name_index,
	output logic                          last
);

	mfcd_pkg::back_state_t           state_q;
	mfcd_pkg::back_state_t           state_d;
	mfcd_pkg::cmd_t                  cmd_q;
	mfcd_pkg::cmd_t                  cmd_code;
	logic [31:0]                     id_q;
	logic [39:0]                     uid_q;
	logic [mfcd_pkg::FCNT_W-1:0]     fcnt_q;
	logic [mfcd_pkg::FCNT_W-1:0]     fcnt_inc;
	logic [mfcd_pkg::NIDX_W-1:0]     nidx_q;
	logic                            ended_q;
	logic [mfcd_pkg::OFF_W-1:0]      off;
	logic [7:0]                      byte_v;
	logic [7:0]                      nb;
	logic                            slot_free;
	logic                            load_out;
	logic                            last_d;
	logic                            res_valid_q;

	assign slot_free = !res_valid_q || !res_stall;
	assign cmd_code  = mfcd_pkg::decode_code(byte_v);
	assign fcnt_inc  = fcnt_q + mfcd_pkg::FCNT_W'(1);
	assign nb        = ended_q ? 8'h00 : byte_v;
	assign last_d    = (state_q == mfcd_pkg::B_EMIT) ||
		(nidx_q == mfcd_pkg::NIDX_W'(mfcd_pkg::NAME_BYTES - 1));

	// Frame offset being read; it is held through the cycle that uses the data.
	always_comb begin
		unique case (state_q)
			mfcd_pkg::B_FLD_RD, mfcd_pkg::B_FLD_USE:
				off = mfcd_pkg::field_offset(cmd_q, fcnt_q);
			mfcd_pkg::B_NAME_RD, mfcd_pkg::B_NAME_USE:
				off = mfcd_pkg::name_base(cmd_q) + mfcd_pkg::OFF_W'(nidx_q);
			default:
				off = mfcd_pkg::OFF_W'(mfcd_pkg::CMD_OFFSET);
		endcase
	end

	// Buffer address within the job's bank; bytes past the frame end read as zero.
	assign raddr  = (q_rd.job.bank ? mfcd_pkg::ADDR_W'(mfcd_pkg::FRAME_BYTES) : '0) +
		mfcd_pkg::ADDR_W'(off);
	assign byte_v = (mfcd_pkg::FILL_W'(off) < q_rd.job.len) ? rdata : 8'h00;

	// Next state, output load and job release.
	always_comb begin
		state_d  = state_q;
		load_out = 1'b0;
		pop      = 1'b0;
		unique case (state_q)
			mfcd_pkg::B_IDLE: begin
				if (q_rd.avail)
					state_d = mfcd_pkg::B_CMD_RD;
			end
			mfcd_pkg::B_CMD_RD:  state_d = mfcd_pkg::B_CMD_USE;
			mfcd_pkg::B_CMD_USE: begin
				if (mfcd_pkg::field_count(cmd_code) != '0)
					state_d = mfcd_pkg::B_FLD_RD;
				else
					state_d = mfcd_pkg::B_EMIT;
			end
			mfcd_pkg::B_FLD_RD:  state_d = mfcd_pkg::B_FLD_USE;
			mfcd_pkg::B_FLD_USE: begin
				if (fcnt_inc != mfcd_pkg::field_count(cmd_q))
					state_d = mfcd_pkg::B_FLD_RD;
				else if (mfcd_pkg::has_name(cmd_q))
					state_d = mfcd_pkg::B_NAME_RD;
				else
					state_d = mfcd_pkg::B_EMIT;
			end
			mfcd_pkg::B_NAME_RD: state_d = mfcd_pkg::B_NAME_USE;
			mfcd_pkg::B_NAME_USE: begin
				if (slot_free) begin
					load_out = 1'b1;
					if (last_d) begin
						pop     = 1'b1;
						state_d = mfcd_pkg::B_IDLE;
					end else begin
						state_d = mfcd_pkg::B_NAME_RD;
					end
				end
			end
			mfcd_pkg::B_EMIT: begin
				if (slot_free) begin
					load_out = 1'b1;
					pop      = 1'b1;
					state_d  = mfcd_pkg::B_IDLE;
				end
			end
			default: state_d = mfcd_pkg::B_IDLE;
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= mfcd_pkg::B_IDLE;
		else
			state_q <= state_d;
	end

	// Field gathering and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q   <= mfcd_pkg::CMD_INVALID;
			id_q    <= '0;
			uid_q   <= '0;
			fcnt_q  <= '0;
			nidx_q  <= '0;
			ended_q <= 1'b0;
		end else begin
			unique case (state_q)
				mfcd_pkg::B_IDLE: begin
					id_q    <= '0;
					uid_q   <= '0;
					fcnt_q  <= '0;
					nidx_q  <= '0;
					ended_q <= 1'b0;
				end
				mfcd_pkg::B_CMD_USE: cmd_q <= cmd_code;
				mfcd_pkg::B_FLD_USE: begin
					if ((cmd_q == mfcd_pkg::CMD_UPDATE) &&
						(fcnt_q < mfcd_pkg::FCNT_W'(mfcd_pkg::UID_BYTES)))
						uid_q <= {uid_q[31:0], byte_v};
					else
						id_q <= {id_q[23:0], byte_v};
					fcnt_q <= fcnt_inc;
				end
				mfcd_pkg::B_NAME_USE: begin
					if (load_out) begin
						ended_q <= ended_q || (nb == 8'h00);
						nidx_q  <= nidx_q + mfcd_pkg::NIDX_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// Output register: valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (load_out)
			res_valid_q <= 1'b1;
		else if (!res_stall)
			res_valid_q <= 1'b0;
	end

	// Output register: payload.
	always_ff @(posedge clk) begin
		if (load_out) begin
			command  <= cmd_q;
			card_id  <= id_q;
			last     <= last_d;
			if (state_q == mfcd_pkg::B_NAME_USE) begin
				card_uid   <= uid_q;
				name_byte  <= nb;
				name_index <= nidx_q;
			end else begin
				card_uid   <= '0;
				name_byte  <= '0;
				name_index <= '0;
			end
		end
	end

	assign res_valid = res_valid_q;

`ifndef SYNTHESIS
	// A job is released only together with its final result.
	a_pop_with_last: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (load_out && last_d))
		else $error("job released without its final result");

	// A job is released only while one is queued.
	a_pop_needs_job: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_rd.avail)
		else $error("job released from an empty queue");

	// Name runs belong to add and update only.
	a_name_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mfcd_pkg::B_NAME_USE) |-> mfcd_pkg::has_name(cmd_q))
		else $error("name run for a command without a name");

	// Single results belong to commands without a name.
	a_emit_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mfcd_pkg::B_EMIT) |-> !mfcd_pkg::has_name(cmd_q))
		else $error("single result for a command with a name");
`endif

endmodule

FILE: src/marker_framed_command_decoder.sv
//------------------------------------------------------------------------------
// marker_framed_command_decoder: framed serial command decoder
// Captures FF AA ... AA FF frames from a byte stream and decodes them.
//------------------------------------------------------------------------------
// The block takes one received byte per cycle while rx_stall is low and buffers
// each frame in one of two banks of a 128-byte RAM; when the end marker arrives
// the frame is queued and a sequencer decodes it while the next frame is
// captured. Decode reads the buffer through its single registered read port,
// with a read state and a use state per byte: the command byte, then for remove
// the id bytes, and for add and update the id or uid bytes and then each name
// byte. Stalled results hold decode. rx_stall rises only while two closed frames
// await decode. The buffer needs no clearing after reset.
module marker_framed_command_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        rx_valid,
	output logic        rx_stall,
	input  logic [7:0]  rx_byte,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [2:0]  command,
	output logic [31:0] card_id,
	output logic [39:0] card_uid,
	output logic [7:0]  name_byte,
	output logic [4:0]  name_index,
	output logic        last
);

	mfcd_pkg::q_wr_t             q_wr;
	mfcd_pkg::q_rd_t             q_rd;
	mfcd_pkg::mem_wr_t           mem_wr;
	logic                        q_full;
	logic                        pop;
	logic [mfcd_pkg::ADDR_W-1:0] raddr;
	logic [7:0]                  rdata;

	// Capture side.
	mfcd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_valid (rx_valid),
		.rx_stall (rx_stall),
		.rx_byte  (rx_byte),
		.q_full   (q_full),
		.q_wr     (q_wr),
		.mem_wr   (mem_wr)
	);

	// Frame buffer, two banks.
	mfcd_ram #(
		.WIDTH (8),
		.DEPTH (mfcd_pkg::MEM_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (mem_wr.we),
		.waddr (mem_wr.addr),
		.wdata (mem_wr.data),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Job queue between capture and decode.
	mfcd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.q_wr   (q_wr),
		.pop    (pop),
		.q_rd   (q_rd),
		.full   (q_full)
	);

	// Decode side.
	mfcd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_rd       (q_rd),
		.pop        (pop),
		.raddr      (raddr),
		.rdata      (rdata),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.command    (command),
		.card_id    (card_id),
		.card_uid   (card_uid),
		.name_byte  (name_byte),
		.name_index (name_index),
		.last       (last)
	);

endmodule
